// ===== rtl/lscf_pkg.sv =====
// Shared types, constants and sequencer tables for the circle fit block.
package lscf_pkg;

  localparam int WIDE_W       = 128;  // solve-phase word, wraps mod 2^128
  localparam int LIMB_W       = 32;   // partial product limb
  localparam int MUL_W        = 33;   // signed multiplier operand
  localparam int PP_NUM       = 10;   // limb pairs with ia + ib < 4
  localparam int TERM_W       = 5;
  localparam int PP_W         = 4;
  localparam int DIV_STEPS    = 128;
  localparam int SQRT_STEPS   = 32;
  localparam int CLAMP_W      = 21;
  localparam int CTR_W        = CLAMP_W + 1;
  localparam int CFG_W        = 16;

  localparam logic [TERM_W-1:0] PHASE_A_LAST  = TERM_W'(15);
  localparam logic [TERM_W-1:0] PHASE_B_FIRST = TERM_W'(16);
  localparam logic [TERM_W-1:0] TERM_LAST     = TERM_W'(24);
  localparam logic [PP_W-1:0]   PP_LAST       = PP_W'(PP_NUM - 1);
  localparam logic [2:0]        POINT_LAST    = 3'd7;

  localparam logic [CLAMP_W-1:0] CENTER_CLAMP     = CLAMP_W'(1048576);
  localparam logic [CFG_W-1:0]   MIN_RADIUS_RESET = CFG_W'(102);
  localparam logic [CFG_W-1:0]   MAX_RADIUS_RESET = CFG_W'(2048);

  typedef enum logic {CFG_MIN_RADIUS, CFG_MAX_RADIUS} cfg_reg_t;

  typedef enum logic [1:0] {
    FIT_OK, FIT_DEGENERATE, FIT_NEG_RADICAND, FIT_OUT_OF_BAND
  } fit_status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POINT, ST_SETUP, ST_MAC, ST_DRAIN, ST_WB,
    ST_CHECK, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {DIV_CX, DIV_CY, DIV_MEAN, DIV_ROOT} div_sel_t;

  typedef enum logic [4:0] {
    OPD_ONE, OPD_N, OPD_SX, OPD_SY, OPD_SXX, OPD_SYY, OPD_SXY,
    OPD_E1, OPD_H1, OPD_S2, OPD_C, OPD_D, OPD_G, OPD_E, OPD_H,
    OPD_DEN, OPD_NUMX, OPD_NUMY, OPD_CX, OPD_CY, OPD_Q1, OPD_Q2, OPD_T
  } opd_t;

  typedef struct packed {
    opd_t a;
    opd_t b;
    logic neg;
    logic last;
    opd_t dst;
  } term_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
  } pp_t;

  typedef struct packed {
    logic start;
    logic root_mode;
  } ds_req_t;

  function automatic term_t mk_term(input opd_t a, input opd_t b, input logic neg,
                                    input logic last, input opd_t dst);
    term_t t;
    t.a = a; t.b = b; t.neg = neg; t.last = last; t.dst = dst;
    return t;
  endfunction

  // Microprogram: each result is a signed sum of wide products.
  function automatic term_t prog_term(input logic [TERM_W-1:0] idx);
    term_t t;
    case (idx)
      5'd0:    t = mk_term(OPD_N,    OPD_SXX, 1'b0, 1'b0, OPD_C);
      5'd1:    t = mk_term(OPD_SX,   OPD_SX,  1'b1, 1'b1, OPD_C);
      5'd2:    t = mk_term(OPD_N,    OPD_SXY, 1'b0, 1'b0, OPD_D);
      5'd3:    t = mk_term(OPD_SX,   OPD_SY,  1'b1, 1'b1, OPD_D);
      5'd4:    t = mk_term(OPD_N,    OPD_SYY, 1'b0, 1'b0, OPD_G);
      5'd5:    t = mk_term(OPD_SY,   OPD_SY,  1'b1, 1'b1, OPD_G);
      5'd6:    t = mk_term(OPD_N,    OPD_E1,  1'b0, 1'b0, OPD_E);
      5'd7:    t = mk_term(OPD_S2,   OPD_SX,  1'b1, 1'b1, OPD_E);
      5'd8:    t = mk_term(OPD_N,    OPD_H1,  1'b0, 1'b0, OPD_H);
      5'd9:    t = mk_term(OPD_S2,   OPD_SY,  1'b1, 1'b1, OPD_H);
      5'd10:   t = mk_term(OPD_C,    OPD_G,   1'b0, 1'b0, OPD_DEN);
      5'd11:   t = mk_term(OPD_D,    OPD_D,   1'b1, 1'b1, OPD_DEN);
      5'd12:   t = mk_term(OPD_E,    OPD_G,   1'b0, 1'b0, OPD_NUMX);
      5'd13:   t = mk_term(OPD_H,    OPD_D,   1'b1, 1'b1, OPD_NUMX);
      5'd14:   t = mk_term(OPD_H,    OPD_C,   1'b0, 1'b0, OPD_NUMY);
      5'd15:   t = mk_term(OPD_E,    OPD_D,   1'b1, 1'b1, OPD_NUMY);
      5'd16:   t = mk_term(OPD_CX,   OPD_CX,  1'b0, 1'b1, OPD_Q1);
      5'd17:   t = mk_term(OPD_CY,   OPD_CY,  1'b0, 1'b1, OPD_Q2);
      5'd18:   t = mk_term(OPD_S2,   OPD_ONE, 1'b0, 1'b0, OPD_T);
      5'd19:   t = mk_term(OPD_CX,   OPD_SX,  1'b1, 1'b0, OPD_T);
      5'd20:   t = mk_term(OPD_CX,   OPD_SX,  1'b1, 1'b0, OPD_T);
      5'd21:   t = mk_term(OPD_N,    OPD_Q1,  1'b0, 1'b0, OPD_T);
      5'd22:   t = mk_term(OPD_CY,   OPD_SY,  1'b1, 1'b0, OPD_T);
      5'd23:   t = mk_term(OPD_CY,   OPD_SY,  1'b1, 1'b0, OPD_T);
      5'd24:   t = mk_term(OPD_N,    OPD_Q2,  1'b0, 1'b1, OPD_T);
      default: t = mk_term(OPD_ONE,  OPD_ONE, 1'b0, 1'b1, OPD_T);
    endcase
    return t;
  endfunction

  // Limb pairs of a product kept mod 2^128.
  function automatic pp_t pp_pair(input logic [PP_W-1:0] k);
    pp_t p;
    case (k)
      4'd0:    p = '{ia: 2'd0, ib: 2'd0};
      4'd1:    p = '{ia: 2'd0, ib: 2'd1};
      4'd2:    p = '{ia: 2'd1, ib: 2'd0};
      4'd3:    p = '{ia: 2'd0, ib: 2'd2};
      4'd4:    p = '{ia: 2'd1, ib: 2'd1};
      4'd5:    p = '{ia: 2'd2, ib: 2'd0};
      4'd6:    p = '{ia: 2'd0, ib: 2'd3};
      4'd7:    p = '{ia: 2'd1, ib: 2'd2};
      4'd8:    p = '{ia: 2'd2, ib: 2'd1};
      4'd9:    p = '{ia: 2'd3, ib: 2'd0};
      default: p = '{ia: 2'd0, ib: 2'd0};
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/lscf_mul.sv =====
// Shared signed multiplier with registered product.
module lscf_mul import lscf_pkg::*; (
  input  logic                        clk,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== rtl/lscf_divsqrt.sv =====
// Shift/compare/subtract unit: restoring divide or square root, one bit per cycle.
module lscf_divsqrt import lscf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ds_req_t           req,
  input  logic [WIDE_W-1:0] num,
  input  logic [WIDE_W-1:0] dvs,
  output logic              done,
  output logic [WIDE_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              mode;
  logic [CNT_W-1:0]  cnt;
  logic [WIDE_W-1:0] nsh;
  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] dreg;
  logic [WIDE_W-1:0] r_shift;
  logic [WIDE_W-1:0] trial;
  logic [WIDE_W-1:0] diff;
  logic              ge;
  logic              last_step;

  always_comb begin
    r_shift   = mode ? {rem[WIDE_W-3:0], nsh[WIDE_W-1 -: 2]} : {rem[WIDE_W-2:0], nsh[WIDE_W-1]};
    trial     = mode ? {quo[WIDE_W-3:0], 2'b01} : dreg;
    ge        = r_shift >= trial;
    diff      = r_shift - trial;
    last_step = mode ? (cnt == CNT_W'(SQRT_STEPS - 1)) : (cnt == CNT_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.root_mode;
      cnt  <= '0;
      nsh  <= num;
      rem  <= '0;
      quo  <= '0;
      dreg <= dvs;
    end else if (busy) begin
      rem <= ge ? diff : r_shift;
      quo <= {quo[WIDE_W-2:0], ge};
      nsh <= mode ? {nsh[WIDE_W-3:0], 2'b00} : {nsh[WIDE_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== rtl/least_squares_circle_fit.sv =====
// Kasa least-squares circle fit: point accumulation and sequenced exact solve.
// A kept point is accepted and then runs seven products through the one multiplier;
// a dropped point that is not last is taken without leaving idle.
// The fit after the last point runs 25 wide product terms of 10 limb products each
// on the shared multiplier, three 128-step divides and a 32-step root.
// Synchronous reset clears the run sums and count, sets radius bounds to 102 and 2048.
module least_squares_circle_fit import lscf_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_stall,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  input  logic                last_point,
  output logic                fit_valid,
  input  logic                fit_stall,
  output logic signed [15:0]  center_x,
  output logic signed [15:0]  center_y,
  output logic [15:0]         radius,
  output logic [1:0]          fit_status,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  // Sum widths follow from the largest point count.
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int S1_W  = 16 + CNT_W;
  localparam int S2_W  = 32 + CNT_W;
  localparam int S3_W  = 48 + CNT_W;

  state_t state, state_next;

  // run state
  logic [CNT_W-1:0]       point_count;
  logic signed [S1_W-1:0] sum_x, sum_y;
  logic signed [S2_W-1:0] sum_x_sq, sum_y_sq, sum_x_y;
  logic signed [S3_W-1:0] sum_x_cube, sum_y_cube, sum_x_y_sq, sum_x_sq_y;

  logic [CFG_W-1:0] min_r, max_r;

  // current point
  logic signed [15:0]      px, py;
  logic                    plast;
  logic [2:0]              step;
  logic signed [MUL_W-1:0] xx, yy;

  // solve registers, the wide ones mod 2^128
  logic [WIDE_W-1:0] e1, h1, s2;
  logic [WIDE_W-1:0] c_v, d_v, g_v, e_v, h_v, den_v, numx, numy, q1, q2, t_v;
  logic [WIDE_W-1:0] acc;
  logic signed [CTR_W-1:0] cx, cy;
  logic [63:0]       mean_sq;

  // microprogram position and pending partial product
  logic [TERM_W-1:0] term;
  logic [PP_W-1:0]   pp;
  logic              pend;
  logic              pend_neg;
  logic [1:0]        pend_sh;
  term_t             cur_term;
  pp_t               cur_pp;
  logic [WIDE_W-1:0] opa_val, opb_val;
  logic [WIDE_W-1:0] sh_val, addend;

  div_sel_t          div_sel;
  ds_req_t           ds_req;
  logic [WIDE_W-1:0] ds_num, ds_dvs;
  logic              ds_done;
  logic [WIDE_W-1:0] ds_quo;
  logic              num_neg;
  logic [WIDE_W-1:0] num_sel, num_abs;
  logic [CLAMP_W-1:0] cmag;
  logic [CTR_W-1:0]   cmag_ext;
  logic [31:0]        root;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  // held result
  logic signed [15:0] res_cx, res_cy;
  logic [15:0]        res_r;
  fit_status_t        res_status;

  logic point_take, point_keep, degen, emit_go;

  lscf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  lscf_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .num  (ds_num),
    .dvs  (ds_dvs),
    .done (ds_done),
    .quo  (ds_quo)
  );

  function automatic logic [WIDE_W-1:0] sel_opd(input opd_t code);
    logic [WIDE_W-1:0] v;
    case (code)
      OPD_ONE:  v = WIDE_W'(1);
      OPD_N:    v = WIDE_W'(point_count);
      OPD_SX:   v = WIDE_W'(sum_x);
      OPD_SY:   v = WIDE_W'(sum_y);
      OPD_SXX:  v = WIDE_W'(sum_x_sq);
      OPD_SYY:  v = WIDE_W'(sum_y_sq);
      OPD_SXY:  v = WIDE_W'(sum_x_y);
      OPD_E1:   v = e1;
      OPD_H1:   v = h1;
      OPD_S2:   v = s2;
      OPD_C:    v = c_v;
      OPD_D:    v = d_v;
      OPD_G:    v = g_v;
      OPD_E:    v = e_v;
      OPD_H:    v = h_v;
      OPD_DEN:  v = den_v;
      OPD_NUMX: v = numx;
      OPD_NUMY: v = numy;
      OPD_CX:   v = WIDE_W'(cx);
      OPD_CY:   v = WIDE_W'(cy);
      OPD_Q1:   v = q1;
      OPD_Q2:   v = q2;
      OPD_T:    v = t_v;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // saturate the internal centre to the 16-bit field
  function automatic logic [15:0] sat16(input logic signed [CTR_W-1:0] v);
    logic [15:0] r;
    if ((&v[CTR_W-1:15]) || !(|v[CTR_W-1:15])) r = v[15:0];
    else if (v[CTR_W-1])                        r = 16'h8000;
    else                                        r = 16'h7fff;
    return r;
  endfunction

  always_comb begin
    cur_term   = prog_term(term);
    cur_pp     = pp_pair(pp);
    opa_val    = sel_opd(cur_term.a);
    opb_val    = sel_opd(cur_term.b);
    point_take = point_valid && (state == ST_IDLE);
    point_keep = point_count < CNT_W'(MAX_POINTS);
    degen      = (point_count == '0) || (den_v == '0) || den_v[WIDE_W-1];
    emit_go    = (state == ST_EMIT) && (!fit_valid || !fit_stall);
    sh_val     = WIDE_W'(prod[2*LIMB_W-1:0]) << (LIMB_W * pend_sh);
    addend     = pend_neg ? ~sh_val : sh_val;
    // centre rounding: (|num| + den) / (2 den)
    num_sel    = (div_sel == DIV_CX) ? numx : numy;
    num_neg    = num_sel[WIDE_W-1];
    num_abs    = num_neg ? -num_sel : num_sel;
    cmag       = (ds_quo > WIDE_W'(CENTER_CLAMP)) ? CENTER_CLAMP : ds_quo[CLAMP_W-1:0];
    cmag_ext   = {1'b0, cmag};
    root       = ds_quo[31:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (point_valid) begin
          if (point_keep)      state_next = ST_POINT;
          else if (last_point) state_next = ST_SETUP;
        end
      end
      ST_POINT: begin
        if (step == POINT_LAST) state_next = plast ? ST_SETUP : ST_IDLE;
      end
      ST_SETUP: state_next = ST_MAC;
      ST_MAC: begin
        if (pp == PP_LAST && cur_term.last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_WB;
      ST_WB: begin
        if (term == PHASE_A_LAST)   state_next = ST_CHECK;
        else if (term == TERM_LAST) state_next = ST_DIV_GO;
        else                        state_next = ST_MAC;
      end
      ST_CHECK: state_next = degen ? ST_EMIT : ST_DIV_GO;
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (ds_done) begin
          unique case (div_sel)
            DIV_CX:   state_next = ST_DIV_GO;
            DIV_CY:   state_next = ST_MAC;
            DIV_MEAN: state_next = ST_DIV_GO;
            DIV_ROOT: state_next = ST_EMIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_EMIT: begin
        if (!fit_valid || !fit_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake, multiplier operands, divider request
  always_comb begin
    point_stall      = (state != ST_IDLE);
    ds_req.start     = (state == ST_DIV_GO);
    ds_req.root_mode = (div_sel == DIV_ROOT);
    mul_a            = '0;
    mul_b            = '0;
    if (state == ST_MAC) begin
      mul_a = {1'b0, opa_val[LIMB_W*cur_pp.ia +: LIMB_W]};
      mul_b = {1'b0, opb_val[LIMB_W*cur_pp.ib +: LIMB_W]};
    end else begin
      case (step)
        3'd0: begin mul_a = MUL_W'(px); mul_b = MUL_W'(px); end
        3'd1: begin mul_a = MUL_W'(py); mul_b = MUL_W'(py); end
        3'd2: begin mul_a = MUL_W'(px); mul_b = MUL_W'(py); end
        3'd3: begin mul_a = xx;         mul_b = MUL_W'(px); end
        3'd4: begin mul_a = yy;         mul_b = MUL_W'(py); end
        3'd5: begin mul_a = MUL_W'(px); mul_b = yy;         end
        3'd6: begin mul_a = xx;         mul_b = MUL_W'(py); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
    case (div_sel)
      DIV_CX, DIV_CY: begin
        ds_num = num_abs + den_v;
        ds_dvs = {den_v[WIDE_W-2:0], 1'b0};
      end
      DIV_MEAN: begin
        ds_num = t_v[WIDE_W-1] ? '0 : t_v;
        ds_dvs = WIDE_W'(point_count);
      end
      default: begin
        ds_num = {mean_sq, 64'h0};
        ds_dvs = '0;
      end
    endcase
  end

  // control state and run sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      sum_x_sq    <= '0;
      sum_y_sq    <= '0;
      sum_x_y     <= '0;
      sum_x_cube  <= '0;
      sum_y_cube  <= '0;
      sum_x_y_sq  <= '0;
      sum_x_sq_y  <= '0;
      fit_valid   <= 1'b0;
      min_r       <= MIN_RADIUS_RESET;
      max_r       <= MAX_RADIUS_RESET;
      pend        <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_MAC);
      if (cfg_write) begin
        case (cfg_index)
          CFG_MIN_RADIUS: min_r <= cfg_data;
          CFG_MAX_RADIUS: max_r <= cfg_data;
          default: ;
        endcase
      end
      if (point_take && point_keep) begin
        point_count <= point_count + 1'b1;
        sum_x       <= sum_x + S1_W'(point_x);
        sum_y       <= sum_y + S1_W'(point_y);
      end
      // product of the previous step lands here
      if (state == ST_POINT) begin
        case (step)
          3'd1: sum_x_sq   <= sum_x_sq   + S2_W'(prod);
          3'd2: sum_y_sq   <= sum_y_sq   + S2_W'(prod);
          3'd3: sum_x_y    <= sum_x_y    + S2_W'(prod);
          3'd4: sum_x_cube <= sum_x_cube + S3_W'(prod);
          3'd5: sum_y_cube <= sum_y_cube + S3_W'(prod);
          3'd6: sum_x_y_sq <= sum_x_y_sq + S3_W'(prod);
          3'd7: sum_x_sq_y <= sum_x_sq_y + S3_W'(prod);
          default: ;
        endcase
      end
      if (emit_go) begin
        fit_valid   <= 1'b1;
        point_count <= '0;
        sum_x       <= '0;
        sum_y       <= '0;
        sum_x_sq    <= '0;
        sum_y_sq    <= '0;
        sum_x_y     <= '0;
        sum_x_cube  <= '0;
        sum_y_cube  <= '0;
        sum_x_y_sq  <= '0;
        sum_x_sq_y  <= '0;
      end else if (!fit_stall) begin
        fit_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= '0;
        if (point_valid) begin
          px    <= point_x;
          py    <= point_y;
          plast <= last_point;
        end
      end
      ST_POINT: begin
        step <= step + 1'b1;
        if (step == 3'd1) xx <= prod[MUL_W-1:0];
        if (step == 3'd2) yy <= prod[MUL_W-1:0];
      end
      ST_SETUP: begin
        e1   <= WIDE_W'(sum_x_cube) + WIDE_W'(sum_x_y_sq);
        h1   <= WIDE_W'(sum_x_sq_y) + WIDE_W'(sum_y_cube);
        s2   <= WIDE_W'(sum_x_sq) + WIDE_W'(sum_y_sq);
        term <= '0;
        pp   <= '0;
        acc  <= '0;
      end
      ST_MAC: begin
        pend_neg <= cur_term.neg;
        pend_sh  <= cur_pp.ia + cur_pp.ib;
        if (pp == PP_LAST) begin
          pp <= '0;
          if (!cur_term.last) term <= term + 1'b1;
        end else begin
          pp <= pp + 1'b1;
        end
      end
      ST_WB: begin
        case (cur_term.dst)
          OPD_C:    c_v   <= acc;
          OPD_D:    d_v   <= acc;
          OPD_G:    g_v   <= acc;
          OPD_E:    e_v   <= acc;
          OPD_H:    h_v   <= acc;
          OPD_DEN:  den_v <= acc;
          OPD_NUMX: numx  <= acc;
          OPD_NUMY: numy  <= acc;
          OPD_Q1:   q1    <= acc;
          OPD_Q2:   q2    <= acc;
          OPD_T:    t_v   <= acc;
          default: ;
        endcase
        acc  <= '0;
        term <= term + 1'b1;
        if (term == TERM_LAST) div_sel <= DIV_MEAN;
      end
      ST_CHECK: begin
        div_sel <= DIV_CX;
        if (degen) begin
          res_cx     <= '0;
          res_cy     <= '0;
          res_r      <= '0;
          res_status <= FIT_DEGENERATE;
        end
      end
      ST_DIV_WAIT: begin
        if (ds_done) begin
          case (div_sel)
            DIV_CX: begin
              cx      <= num_neg ? -cmag_ext : cmag_ext;
              div_sel <= DIV_CY;
            end
            DIV_CY: begin
              cy   <= num_neg ? -cmag_ext : cmag_ext;
              term <= PHASE_B_FIRST;
              pp   <= '0;
            end
            DIV_MEAN: begin
              mean_sq <= ds_quo[63:0];
              div_sel <= DIV_ROOT;
            end
            default: begin
              res_cx     <= sat16(cx);
              res_cy     <= sat16(cy);
              res_r      <= (|root[31:16]) ? 16'hffff : root[15:0];
              res_status <= (root > 32'(min_r) && root < 32'(max_r)) ? FIT_OK
                                                                     : FIT_OUT_OF_BAND;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          center_x   <= res_cx;
          center_y   <= res_cy;
          radius     <= res_r;
          fit_status <= res_status;
        end
      end
      default: ;
    endcase
    // limb product issued last cycle
    if (pend) acc <= acc + addend + WIDE_W'(pend_neg);
  end

endmodule

// ===== tb/least_squares_circle_fit_test.sv =====
// Testbench for the least-squares circle fit: point requests in, fit results checked.
`timescale 1ns / 100ps

module least_squares_circle_fit_test;
  import lscf_pkg::*;

  localparam int MAX_PTS   = 64;
  localparam int CYC_LIMIT = 2000000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [15:0]        rad;
    fit_status_t        status;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic last_point = 1'b0;
  logic fit_valid;
  logic fit_stall = 1'b0;
  logic signed [15:0] center_x, center_y;
  logic [15:0] radius;
  logic [1:0] fit_status;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  least_squares_circle_fit #(.MAX_POINTS(MAX_PTS)) u_top (.*);

  always #6 clk = ~clk;

  // pending point requests and the fits they should produce
  point_t pending_points[$];
  fit_t   expected_fits[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     no_idle = 1'b0;   // phase with back-to-back traffic on both sides

  // Shadow of the block: run count, power sums and radius band.
  int unsigned run_count;
  longint sx, sy, sxx, syy, sxxx, syyy, sxy, sxyy, sxxy;
  logic [15:0] band_lo, band_hi;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // num / (2*den), rounded half away from zero, clamped; all mod 2^128 like the hw
  function automatic longint centre_round(logic [127:0] num, logic [127:0] den);
    logic         neg;
    logic [127:0] mag, q;
    longint       v;
    neg = num[127];
    mag = neg ? -num : num;
    q = (mag + den) / (den + den);
    v = (q > 128'(CENTER_CLAMP)) ? longint'(CENTER_CLAMP) : longint'(q[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic logic [15:0] sat_s16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void clear_sums();
    run_count = 0;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxxx = 0; syyy = 0;
    sxy = 0; sxyy = 0; sxxy = 0;
  endfunction

  // Fold one accepted point in; on the last one push the expected fit.
  function automatic void fold_point(point_t p);
    longint x, y, n, cx, cy, t;
    logic signed [127:0] c, d, g, e, h, den, s2, wn;
    longint unsigned r;
    fit_t f;
    x = p.x;
    y = p.y;
    if (run_count < MAX_PTS) begin
      run_count++;
      sx += x; sy += y; sxx += x * x; syy += y * y;
      sxxx += x * x * x; syyy += y * y * y;
      sxy += x * y; sxyy += x * y * y; sxxy += x * x * y;
    end
    if (!p.last) return;
    n = run_count;
    wn = n;
    c = wn * 128'(signed'(sxx)) - 128'(signed'(sx)) * 128'(signed'(sx));
    d = wn * 128'(signed'(sxy)) - 128'(signed'(sx)) * 128'(signed'(sy));
    g = wn * 128'(signed'(syy)) - 128'(signed'(sy)) * 128'(signed'(sy));
    s2 = 128'(signed'(sxx)) + 128'(signed'(syy));
    e = wn * (128'(signed'(sxxx)) + 128'(signed'(sxyy))) - s2 * 128'(signed'(sx));
    h = wn * (128'(signed'(sxxy)) + 128'(signed'(syyy))) - s2 * 128'(signed'(sy));
    den = c * g - d * d;
    if (n == 0 || den == 0 || den[127]) begin
      f = '{cx: '0, cy: '0, rad: '0, status: FIT_DEGENERATE};
    end else begin
      cx = centre_round(e * g - h * d, den);
      cy = centre_round(h * c - e * d, den);
      t = sxx - 2 * cx * sx + n * cx * cx + syy - 2 * cy * sy + n * cy * cy;
      if (t < 0) t = 0;
      r = root_floor(longint'(unsigned'(t)) / longint'(unsigned'(n)));
      f.cx = sat_s16(cx);
      f.cy = sat_s16(cy);
      f.rad = (r > 65535) ? 16'hFFFF : r[15:0];
      f.status = (r > band_lo && r < band_hi) ? FIT_OK : FIT_OUT_OF_BAND;
    end
    expected_fits.push_back(f);
    clear_sums();
  endfunction

  // Driver: presents queued requests, with a random gap after each accepted one.
  int gap_left = 0;
  always @(posedge clk) begin
    point_t p;
    logic   hold, nv;
    if (rst) begin
      point_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (point_valid && !point_stall) begin
        fold_point('{x: point_x, y: point_y, last: last_point});
        gap_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      hold = point_valid && point_stall;  // stalled request stays put
      nv = hold;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_points.size() > 0) begin
          p = pending_points.pop_front();
          point_x <= p.x;
          point_y <= p.y;
          last_point <= p.last;
          nv = 1'b1;
        end
      end
      point_valid <= nv;
    end
  end

  // Monitor: random stall after each fit, checks every field.
  int stall_left = 0;
  always @(posedge clk) begin
    fit_t f;
    if (rst) begin
      fit_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (fit_valid && !fit_stall) begin
        if (expected_fits.size() == 0) begin
          $display("%0t: unexpected fit cx=%0d cy=%0d r=%0d st=%0d", $time,
                   center_x, center_y, radius, fit_status);
          fail_count++;
        end else begin
          f = expected_fits.pop_front();
          if (center_x !== f.cx) begin
            $display("%0t: center_x expected %0d actual %0d", $time, f.cx, center_x);
            fail_count++;
          end
          if (center_y !== f.cy) begin
            $display("%0t: center_y expected %0d actual %0d", $time, f.cy, center_y);
            fail_count++;
          end
          if (radius !== f.rad) begin
            $display("%0t: radius expected %0d actual %0d", $time, f.rad, radius);
            fail_count++;
          end
          if (fit_status !== f.status) begin
            $display("%0t: fit_status expected %0d actual %0d", $time, f.status,
                     fit_status);
            fail_count++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        fit_stall <= 1'b1;
      end else begin
        fit_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYC_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // cos/sin * 1024 at 22.5 degree steps
  int cos_tab[16] = '{1024, 946, 724, 392, 0, -392, -724, -946,
                      -1024, -946, -724, -392, 0, 392, 724, 946};

  function automatic logic signed [15:0] clip16(longint v);
    return sat_s16(v);
  endfunction

  function automatic void add_point(longint x, longint y, logic last);
    pending_points.push_back('{x: clip16(x), y: clip16(y), last: last});
  endfunction

  // Points on a circle with a little jitter; the last one closes the run.
  function automatic void add_circle(int n, longint cx, longint cy, longint r, int jit);
    int a;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(0, 15);
      add_point(cx + (r * cos_tab[a]) / 1024 + int'($urandom_range(0, 2 * jit)) - jit,
                cy + (r * cos_tab[(a + 12) % 16]) / 1024
                   + int'($urandom_range(0, 2 * jit)) - jit,
                i == n - 1);
    end
  endfunction

  function automatic void add_noise_run(int n);
    for (int i = 0; i < n; i++)
      add_point(longint'(signed'(16'($urandom))), longint'(signed'(16'($urandom))),
                i == n - 1);
  endfunction

  // Let the queue drain and every fit arrive, then a short settle.
  task automatic wait_idle();
    while (pending_points.size() > 0 || point_valid || expected_fits.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_band(logic [15:0] lo, logic [15:0] hi);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MIN_RADIUS;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_RADIUS;
    cfg_data <= hi;
    @(posedge clk);
    cfg_write <= 1'b0;
    band_lo = lo;
    band_hi = hi;
  endtask

  int sent;
  int n;

  initial begin
    clear_sums();
    band_lo = MIN_RADIUS_RESET;
    band_hi = MAX_RADIUS_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset band first
    add_point(100, 100, 1'b1);                      // lone point: degenerate
    add_point(0, 0, 1'b0); add_point(500, 0, 1'b1); // two points
    add_point(0, 0, 1'b0); add_point(100, 100, 1'b0); add_point(200, 200, 1'b1);
    add_point(-32768, -32768, 1'b0); add_point(32767, -32768, 1'b0);
    add_point(32767, 32767, 1'b0); add_point(-32768, 32767, 1'b1);
    add_point(1024, 0, 1'b0); add_point(0, 1024, 1'b0); add_point(-1024, 0, 1'b1);
    add_point(30000, 30000, 1'b0); add_point(30001, 30000, 1'b0);
    add_point(30000, 30001, 1'b1);                  // tiny radius, below band
    add_point(-20, 0, 1'b0); add_point(0, 20000, 1'b0); add_point(20, 0, 1'b1);
    wait_idle();

    // Overfull run: points past the cap are dropped, last one still fires
    for (int i = 0; i < MAX_PTS + 5; i++)
      add_point($urandom_range(0, 4000), $urandom_range(0, 4000), i == MAX_PTS + 4);
    wait_idle();

    // Random phases across several band settings, extremes included
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_band(16'd0, 16'hFFFF);
        1: write_band(16'hFFFF, 16'd0);
        2: write_band(MIN_RADIUS_RESET, MAX_RADIUS_RESET);
        3: write_band(16'($urandom_range(0, 2000)), 16'($urandom_range(1000, 65535)));
        default: write_band(16'($urandom), 16'($urandom));
      endcase
      no_idle = (ph == 2);
      while (sent < (ph + 1) * 130) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(3, 12);
        case ($urandom_range(0, 5))
          0: add_noise_run(n);
          1: add_circle(n, $signed($urandom_range(0, 60000)) - 30000,
                        $signed($urandom_range(0, 60000)) - 30000,
                        $urandom_range(1, 20000), 3);
          default: add_circle(n, $signed($urandom_range(0, 4000)) - 2000,
                              $signed($urandom_range(0, 4000)) - 2000,
                              $urandom_range(50, 3000), $urandom_range(0, 8));
        endcase
        sent += n;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
